/* src/dfa_pkg.sv */
// Shared types and constants for the automaton word acceptor.
// Holds field widths, table geometry, command and register codes.
// No dependencies.
`default_nettype none

package dfa_pkg;

   localparam int STATE_W    = 4;
   localparam int SYM_W      = 8;
   localparam int NUM_STATES = 16;
   localparam int ROW_W      = NUM_STATES * SYM_W;
   localparam int MASK_W     = 16;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_FEED  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_START_STATE = 1'b0,
      CSR_FINAL_MASK  = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } fsm_type;

   // A state number outside the table has no row.
   function automatic logic state_in_range(input logic [STATE_W-1:0] s);
      state_in_range = ({1'b0, s} < (STATE_W + 1)'(NUM_STATES));
   endfunction

endpackage

`default_nettype wire

/* src/dfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/dfa_word_acceptor.sv */
// Automaton word acceptor: transition table in a row-wide RAM, one row per state.
// Every command is one RAM read of a row, then compare or merge and write.
// rsp_valid strobes the result, registered from busy after the execute state; busy is
// high while executing, so a new command waits for idle. The receiver cannot stall.
// Reset (synchronous): table rows marked empty via per-row valid bits, run at state 0
// and alive, start_state and final_mask zero. Depends on dfa_pkg and dfa_ram.
`default_nettype none

module dfa_word_acceptor
   import dfa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_command,
   input  wire logic [STATE_W-1:0] req_from_state,
   input  wire logic [STATE_W-1:0] req_to_state,
   input  wire logic [SYM_W-1:0]   req_symbol,
   output logic                    rsp_valid,
   output logic [STATE_W-1:0]      rsp_current_state,
   output logic                    rsp_alive,
   output logic                    rsp_accepted,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [MASK_W-1:0]  csr_wdata
);

   fsm_type              state_ff, state_in;
   cmd_type              cmd_ff;
   logic [STATE_W-1:0]   from_ff, to_ff;
   logic [SYM_W-1:0]     sym_ff;
   logic [STATE_W-1:0]   run_state_ff, run_state_in;
   logic                 run_alive_ff, run_alive_in;
   logic [STATE_W-1:0]   start_state_ff;
   logic [MASK_W-1:0]    final_mask_ff;
   logic [NUM_STATES-1:0] row_valid_ff;
   logic                 rd_valid_ff;
   logic                 rsp_valid_ff;
   logic [STATE_W-1:0]   rsp_state_ff;
   logic                 rsp_alive_ff, rsp_accepted_ff;

   logic                 accept;
   logic                 rd_en;
   logic [STATE_W-1:0]   rd_addr;
   logic [ROW_W-1:0]     rd_data, row;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_data;
   logic [NUM_STATES-1:0] match;
   logic [STATE_W-1:0]   hit_state;
   logic                 hit;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff == ST_EXEC);
   assign csr_ready = 1'b1;

   // Load reads the row it will modify; every other command reads the current row.
   assign rd_en   = accept;
   assign rd_addr = (cmd_type'(req_command) == CMD_LOAD) ? req_from_state : run_state_ff;

   dfa_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NUM_STATES)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(from_ff),
      .wr_data(wr_data)
   );

   // A row never written since reset reads as all empty cells.
   assign row = rd_valid_ff ? rd_data : '0;

   always_comb begin
      match     = '0;
      hit_state = '0;
      for (int j = 0; j < NUM_STATES; j++) begin
         match[j] = (row[j*SYM_W +: SYM_W] == sym_ff);
      end
      // Lowest target wins.
      for (int j = NUM_STATES - 1; j >= 0; j--) begin
         if (match[j]) begin
            hit_state = STATE_W'(j);
         end
      end
      hit = (|match) && (sym_ff != '0) && state_in_range(run_state_ff);
   end

   always_comb begin
      wr_data = row;
      wr_data[to_ff*SYM_W +: SYM_W] = sym_ff;
   end

   always_comb begin
      state_in     = state_ff;
      run_state_in = run_state_ff;
      run_alive_in = run_alive_ff;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cmd_ff)
               CMD_LOAD: begin
                  wr_en = state_in_range(from_ff) && state_in_range(to_ff);
               end
               CMD_BEGIN: begin
                  run_state_in = start_state_ff;
                  run_alive_in = 1'b1;
               end
               CMD_FEED: begin
                  if (run_alive_ff) begin
                     if (hit) begin
                        run_state_in = hit_state;
                     end else begin
                        run_alive_in = 1'b0;
                     end
                  end
               end
               CMD_NONE: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         run_state_ff   <= '0;
         run_alive_ff   <= 1'b1;
         row_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         start_state_ff <= '0;
         final_mask_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         run_state_ff <= run_state_in;
         run_alive_ff <= run_alive_in;
         rsp_valid_ff <= busy;
         if (wr_en) begin
            row_valid_ff[from_ff] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_START_STATE: start_state_ff <= csr_wdata[STATE_W-1:0];
               CSR_FINAL_MASK:  final_mask_ff  <= csr_wdata;
            endcase
         end
      end
   end

   // Payload: capture on transfer, result on the execute cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= cmd_type'(req_command);
         from_ff     <= req_from_state;
         to_ff       <= req_to_state;
         sym_ff      <= req_symbol;
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
      if (busy) begin
         rsp_state_ff    <= run_state_in;
         rsp_alive_ff    <= run_alive_in;
         rsp_accepted_ff <= run_alive_in && final_mask_ff[run_state_in];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_state = rsp_state_ff;
   assign rsp_alive         = rsp_alive_ff;
   assign rsp_accepted      = rsp_accepted_ff;

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("command transfer not followed by execute cycle");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding execute cycle");

   a_write_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (busy && (cmd_ff == CMD_LOAD)))
      else $error("table write outside a load execute cycle");

   a_accept_implies_alive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> rsp_alive)
      else $error("accepted reported on a dead run");

endmodule

`default_nettype wire
